// ----- design/gfra_pkg.sv -----
// ----------------------------------------------------------------------------
// gfra_pkg
// Shared types and constants of the gamepad frame report averager.
// ----------------------------------------------------------------------------
package gfra_pkg;

  localparam int AXIS_W        = 16;
  localparam int CNT_W         = 8;
  localparam int DZ_W          = 15;
  localparam int NUM_W         = 24;  // magnitude of avg*n + v
  localparam int DIV_W         = CNT_W + 1;
  localparam int BITS_PER_STEP = 2;
  localparam int DIV_STEPS     = NUM_W / BITS_PER_STEP;
  localparam int NUM_LANES     = 6;   // four sticks, two triggers
  localparam int NUM_STICKS    = 4;

  localparam logic [DZ_W-1:0] DEAD_ZONE_RESET = 15'd1638;

  typedef struct packed {
    logic capture;
    logic mul;
    logic div;
    logic commit_first;
    logic commit_avg;
  } lane_ctrl_t;

  typedef struct packed {
    logic [AXIS_W-1:0] buttons;
    logic [AXIS_W-1:0] changed;
    logic [AXIS_W-1:0] left_x;
    logic [AXIS_W-1:0] left_y;
    logic [AXIS_W-1:0] right_x;
    logic [AXIS_W-1:0] right_y;
    logic [AXIS_W-1:0] trig_left;
    logic [AXIS_W-1:0] trig_right;
    logic [CNT_W-1:0]  count;
  } result_t;

endpackage

// ----- design/gfra_lane.sv -----
// ----------------------------------------------------------------------------
// gfra_lane
// One averaging lane: multiply-accumulate then radix-4 restoring divide.
// ----------------------------------------------------------------------------
module gfra_lane #(
  parameter bit SIGNED_LANE = 1'b1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gfra_pkg::lane_ctrl_t        ctrl,
  input  logic [gfra_pkg::AXIS_W-1:0] val_in,
  input  logic [gfra_pkg::CNT_W-1:0]  n,
  input  logic [gfra_pkg::DIV_W-1:0]  d,
  output logic [gfra_pkg::AXIS_W-1:0] avg
);
  import gfra_pkg::*;

  logic [AXIS_W-1:0] val_r;
  logic [AXIS_W-1:0] avg_r;
  logic              neg_r;
  logic [NUM_W-1:0]  dvd_r;
  logic [DIV_W-1:0]  rem_r;

  logic signed [AXIS_W:0]   avg_x;
  logic signed [AXIS_W:0]   val_x;
  logic signed [NUM_W+1:0]  prod;
  logic signed [NUM_W+1:0]  num;
  logic [NUM_W-1:0]         mag;
  logic [DIV_W:0]           s1;
  logic [DIV_W:0]           s2;
  logic [AXIS_W-1:0]        quot;

  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                              input logic b,
                                              input logic [DIV_W-1:0] dv);
    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    trial = {rem, b};
    diff  = trial - {1'b0, dv};
    if (trial >= {1'b0, dv}) begin
      return {1'b1, diff[DIV_W-1:0]};
    end
    return {1'b0, trial[DIV_W-1:0]};
  endfunction

  assign avg_x = SIGNED_LANE ? $signed({avg_r[AXIS_W-1], avg_r}) : $signed({1'b0, avg_r});
  assign val_x = SIGNED_LANE ? $signed({val_r[AXIS_W-1], val_r}) : $signed({1'b0, val_r});
  assign prod  = (NUM_W+2)'(avg_x * $signed({1'b0, n}));
  assign num   = prod + (NUM_W+2)'(val_x);
  assign mag   = num[NUM_W+1] ? NUM_W'(-num) : num[NUM_W-1:0];

  assign s1   = div_step(rem_r, dvd_r[NUM_W-1], d);
  assign s2   = div_step(s1[DIV_W-1:0], dvd_r[NUM_W-2], d);
  assign quot = neg_r ? AXIS_W'(-dvd_r) : dvd_r[AXIS_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      val_r <= val_in;
    end
    if (ctrl.mul) begin
      neg_r <= num[NUM_W+1];
      dvd_r <= mag;
      rem_r <= '0;
    end else if (ctrl.div) begin
      dvd_r <= {dvd_r[NUM_W-3:0], s1[DIV_W], s2[DIV_W]};
      rem_r <= s2[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= '0;
    end else if (ctrl.commit_first) begin
      avg_r <= val_r;
    end else if (ctrl.commit_avg) begin
      avg_r <= quot;
    end
  end

  assign avg = ctrl.commit_first ? val_r : (ctrl.commit_avg ? quot : avg_r);

endmodule

// ----- design/gfra_merge.sv -----
// ----------------------------------------------------------------------------
// gfra_merge
// Merging stage: gathers lane averages, buttons and count into the result
// register that drives the output channel.
// ----------------------------------------------------------------------------
module gfra_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  gfra_pkg::result_t           res_in,
  output logic                        free,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [gfra_pkg::AXIS_W-1:0] out_buttons_out,
  output logic [gfra_pkg::AXIS_W-1:0] out_changed_out,
  output logic [gfra_pkg::AXIS_W-1:0] out_left_x_avg,
  output logic [gfra_pkg::AXIS_W-1:0] out_left_y_avg,
  output logic [gfra_pkg::AXIS_W-1:0] out_right_x_avg,
  output logic [gfra_pkg::AXIS_W-1:0] out_right_y_avg,
  output logic [gfra_pkg::AXIS_W-1:0] out_trig_left_avg,
  output logic [gfra_pkg::AXIS_W-1:0] out_trig_right_avg,
  output logic [gfra_pkg::CNT_W-1:0]  out_report_count
);
  import gfra_pkg::*;

  result_t res_r;
  logic    valid_r;

  assign free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid          = valid_r;
  assign out_buttons_out    = res_r.buttons;
  assign out_changed_out    = res_r.changed;
  assign out_left_x_avg     = res_r.left_x;
  assign out_left_y_avg     = res_r.left_y;
  assign out_right_x_avg    = res_r.right_x;
  assign out_right_y_avg    = res_r.right_y;
  assign out_trig_left_avg  = res_r.trig_left;
  assign out_trig_right_avg = res_r.trig_right;
  assign out_report_count   = res_r.count;

endmodule

// ----- design/gamepad_frame_report_averager.sv -----
// ----------------------------------------------------------------------------
// gamepad_frame_report_averager
// Merges gamepad reports within a frame: dead zone on sticks, changed-button
// tracking and running averages of sticks and triggers in six lanes.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  func, buttons, 4 sticks, 2 triggers
//   out      output     out_valid/out_stall buttons, changed, 6 averages, count
//   cfg      input      cfg_wr_en          dead zone (15 bits)
//
// A frame tick or the first report of a frame goes from idle straight to merge.
// A later report passes a multiply-add step, the divide steps (two
// quotient bits per cycle in each lane, under one shared step counter) and merge.
// One item is in work at a time; the next is taken in the cycle after merge.
// Reset is synchronous; state clears at once, no clearing pass.
// A stalled result holds in the merge register while the next item runs.
// ----------------------------------------------------------------------------
module gamepad_frame_report_averager #(
  parameter int MAX_REPORTS = 255
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [gfra_pkg::DZ_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_func,
  input  logic [gfra_pkg::AXIS_W-1:0] in_buttons_in,
  input  logic [gfra_pkg::AXIS_W-1:0] in_left_x_in,
  input  logic [gfra_pkg::AXIS_W-1:0] in_left_y_in,
  input  logic [gfra_pkg::AXIS_W-1:0] in_right_x_in,
  input  logic [gfra_pkg::AXIS_W-1:0] in_right_y_in,
  input  logic [gfra_pkg::AXIS_W-1:0] in_trig_left_in,
  input  logic [gfra_pkg::AXIS_W-1:0] in_trig_right_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gfra_pkg::AXIS_W-1:0] out_buttons_out,
  output logic [gfra_pkg::AXIS_W-1:0] out_changed_out,
  output logic [gfra_pkg::AXIS_W-1:0] out_left_x_avg,
  output logic [gfra_pkg::AXIS_W-1:0] out_left_y_avg,
  output logic [gfra_pkg::AXIS_W-1:0] out_right_x_avg,
  output logic [gfra_pkg::AXIS_W-1:0] out_right_y_avg,
  output logic [gfra_pkg::AXIS_W-1:0] out_trig_left_avg,
  output logic [gfra_pkg::AXIS_W-1:0] out_trig_right_avg,
  output logic [gfra_pkg::CNT_W-1:0]  out_report_count
);
  import gfra_pkg::*;

  localparam int LIMIT_I = (MAX_REPORTS > 255) ? 255 : MAX_REPORTS;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(LIMIT_I);
  localparam int DC_W = $clog2(DIV_STEPS);
  localparam logic [DC_W-1:0] DIV_LAST = DC_W'(DIV_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [DC_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic [DZ_W-1:0]   dz_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  n_r;
  logic [AXIS_W-1:0] held_r;
  logic [AXIS_W-1:0] changed_r;
  logic              report_r;
  logic              first_r;

  logic              in_acc;
  logic              merge_free;
  logic              merge_load;
  lane_ctrl_t        lctrl;
  result_t           res;
  logic [AXIS_W-1:0] lane_in  [NUM_LANES];
  logic [AXIS_W-1:0] lane_avg [NUM_LANES];
  logic [DIV_W-1:0]  d;

  function automatic logic [AXIS_W-1:0] dead_zone(input logic [AXIS_W-1:0] v,
                                                  input logic [DZ_W-1:0] dz);
    logic [AXIS_W:0] mag;
    mag = v[AXIS_W-1] ? ({1'b0, ~v} + 17'd1) : {1'b0, v};
    if (mag < {2'b00, dz}) begin
      return '0;
    end
    return v;
  endfunction

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign merge_load = (state_r == S_FIN) && merge_free;
  assign d          = {1'b0, n_r} + DIV_W'(1);

  assign lane_in[0] = dead_zone(in_left_x_in, dz_r);
  assign lane_in[1] = dead_zone(in_left_y_in, dz_r);
  assign lane_in[2] = dead_zone(in_right_x_in, dz_r);
  assign lane_in[3] = dead_zone(in_right_y_in, dz_r);
  assign lane_in[4] = in_trig_left_in;
  assign lane_in[5] = in_trig_right_in;

  always_comb begin
    lctrl.capture      = in_acc && !in_func;
    lctrl.mul          = (state_r == S_MUL);
    lctrl.div          = (state_r == S_DIV);
    lctrl.commit_first = merge_load && report_r && first_r;
    lctrl.commit_avg   = merge_load && report_r && !first_r;
  end

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_func || count_r == '0) ? S_FIN : S_MUL;
        end
      end
      S_MUL: begin
        state_nxt   = S_DIV;
        div_cnt_nxt = '0;
      end
      S_DIV: begin
        div_cnt_nxt = div_cnt_r + DC_W'(1);
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (merge_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_cnt_r <= '0;
      dz_r      <= DEAD_ZONE_RESET;
      count_r   <= '0;
      held_r    <= '0;
      changed_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
      if (cfg_wr_en) begin
        dz_r <= cfg_wr_data;
      end
      if (in_acc) begin
        if (in_func) begin
          count_r <= '0;
        end else begin
          held_r <= in_buttons_in;
          if (count_r == '0) begin
            changed_r <= held_r ^ in_buttons_in;
          end else begin
            changed_r <= changed_r | (held_r ^ in_buttons_in);
          end
          if (count_r < COUNT_LIMIT) begin
            count_r <= count_r + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      report_r <= !in_func;
      first_r  <= (count_r == '0);
      n_r      <= count_r;
    end
  end

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    gfra_lane #(
      .SIGNED_LANE(i < NUM_STICKS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (lctrl),
      .val_in (lane_in[i]),
      .n      (n_r),
      .d      (d),
      .avg    (lane_avg[i])
    );
  end

  // averages are taken from the next lane values so the result shows them
  always_comb begin
    res.buttons    = held_r;
    res.changed    = changed_r;
    res.count      = count_r;
    res.left_x     = lane_avg[0];
    res.left_y     = lane_avg[1];
    res.right_x    = lane_avg[2];
    res.right_y    = lane_avg[3];
    res.trig_left  = lane_avg[4];
    res.trig_right = lane_avg[5];
  end

  gfra_merge u_merge (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (merge_load),
    .res_in             (res),
    .free               (merge_free),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_buttons_out    (out_buttons_out),
    .out_changed_out    (out_changed_out),
    .out_left_x_avg     (out_left_x_avg),
    .out_left_y_avg     (out_left_y_avg),
    .out_right_x_avg    (out_right_x_avg),
    .out_right_y_avg    (out_right_y_avg),
    .out_trig_left_avg  (out_trig_left_avg),
    .out_trig_right_avg (out_trig_right_avg),
    .out_report_count   (out_report_count)
  );

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_LIMIT)
    else $error("report count above limit");

  a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_func |=> count_r == '0 && state_r == S_FIN)
    else $error("frame tick did not clear count");

  a_later_divides: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_func && count_r != '0 |=> state_r == S_MUL)
    else $error("later report skipped the average");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && div_cnt_r == DIV_LAST |=> state_r == S_FIN)
    else $error("divide did not finish on time");

endmodule
